FILE: rtl/sparse_vector_reduction_assert.svh
// assertion macros shared by the reduction block
`ifndef SPARSE_VECTOR_REDUCTION_ASSERT_SVH
`define SPARSE_VECTOR_REDUCTION_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SVR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sparse_vector_reduction: check failed");

// next-cycle implication, checked out of reset
`define SVR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sparse_vector_reduction: check failed");

`endif

FILE: rtl/svr_pkg.sv
package svr_pkg;

  localparam int unsigned COEFF_BITS  = 32;
  localparam int unsigned VAR_ID_BITS = 16;
  localparam int unsigned EXCL_BITS   = 16;
  localparam int unsigned DIM_BITS    = 16;
  localparam int unsigned SUM_BITS    = 48;
  localparam int unsigned VAL_BITS    = 32;
  localparam int unsigned MAG_BITS    = 31;
  localparam int unsigned K_BITS      = $clog2(MAG_BITS);

  typedef struct packed {
    logic                start;
    logic [MAG_BITS-1:0] a;
    logic [MAG_BITS-1:0] b;
  } gcd_req_t;

  typedef struct packed {
    logic                done;
    logic [MAG_BITS-1:0] result;
  } gcd_rsp_t;

endpackage

FILE: rtl/svr_gcd.sv
module svr_gcd (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  svr_pkg::gcd_req_t  req_i,
  output svr_pkg::gcd_rsp_t  rsp_o
);

  localparam int unsigned MagBits = svr_pkg::MAG_BITS;
  localparam int unsigned KBits   = svr_pkg::K_BITS;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_REDUCE  = 2'd1;
  localparam logic [1:0] ST_RESTORE = 2'd2;

  logic [1:0]         st_q, st_d;
  logic [MagBits-1:0] a_q, a_d, b_q, b_d;
  logic [KBits-1:0]   k_q, k_d;
  logic [MagBits:0]   diff;

  assign diff = {1'b0, a_q} - {1'b0, b_q};

  // binary gcd, one shift or one subtract per cycle
  always_comb begin
    st_d = st_q;
    a_d  = a_q;
    b_d  = b_q;
    k_d  = k_q;
    case (st_q)
      ST_IDLE: begin
        if (req_i.start) begin
          a_d  = req_i.a;
          b_d  = req_i.b;
          k_d  = '0;
          st_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (b_q == '0) begin
          st_d = ST_RESTORE;
        end else begin
          case ({a_q[0], b_q[0]})
            2'b00: begin
              a_d = a_q >> 1;
              b_d = b_q >> 1;
              k_d = k_q + 1'b1;
            end
            2'b01: a_d = a_q >> 1;
            2'b10: b_d = b_q >> 1;
            default: begin
              // both odd: the difference is even and shifts out next
              if (diff[MagBits]) begin
                b_d = b_q - a_q;
              end else if (diff == '0) begin
                b_d = '0;
              end else begin
                a_d = diff[MagBits-1:0];
              end
            end
          endcase
        end
      end
      ST_RESTORE: begin
        // put back the common powers of two
        if (k_q == '0) begin
          st_d = ST_IDLE;
        end else begin
          a_d = a_q << 1;
          k_d = k_q - 1'b1;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      k_q  <= '0;
    end else begin
      st_q <= st_d;
      k_q  <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign rsp_o.done   = (st_q == ST_RESTORE) && (k_q == '0);
  assign rsp_o.result = a_q;

endmodule

FILE: rtl/sparse_vector_reduction.sv
// Streaming reduction of a sparse integer vector, one term per input beat. On the beat
// flagged last, one result beat gives the count of non-constant terms, the saturating
// sum, max(0, largest), min(0, smallest), the GCD of all non-zero |coeff| and the same
// GCD without the terms of the configured excluded variable (both 1 when empty); the
// accumulators then clear. Coefficients are clamped to +/-(2^31 - 1). The block takes
// one beat at a time and stalls its input until the beat is fully folded in; a term
// needs up to two runs of the shared binary-GCD unit (one shift or one 31-bit
// subtract per cycle). A finished result waits in an output register while the
// next beats are taken; a last beat only holds in its final state if that register is
// still full and stalled. The excluded_variable register may be written at any time
// the block is idle.
`include "sparse_vector_reduction_assert.svh"

module sparse_vector_reduction #(
  parameter int unsigned COEFF_BITS  = svr_pkg::COEFF_BITS,
  parameter int unsigned VAR_ID_BITS = svr_pkg::VAR_ID_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [svr_pkg::EXCL_BITS-1:0]        cfg_data_i,
  // input terms
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [VAR_ID_BITS-1:0]               variable_id_i,
  input  logic signed [COEFF_BITS-1:0]         coeff_i,
  input  logic                                 no_term_i,
  input  logic                                 last_i,
  // results
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [svr_pkg::DIM_BITS-1:0]         dimension_o,
  output logic signed [svr_pkg::SUM_BITS-1:0]  coeff_sum_o,
  output logic [svr_pkg::MAG_BITS-1:0]         max_or_zero_o,
  output logic signed [svr_pkg::VAL_BITS-1:0]  min_or_zero_o,
  output logic [svr_pkg::MAG_BITS-1:0]         gcd_all_o,
  output logic [svr_pkg::MAG_BITS-1:0]         gcd_except_o
);

  localparam int unsigned ExclBits  = svr_pkg::EXCL_BITS;
  localparam int unsigned DimBits   = svr_pkg::DIM_BITS;
  localparam int unsigned SumBits   = svr_pkg::SUM_BITS;
  localparam int unsigned ValBits   = svr_pkg::VAL_BITS;
  localparam int unsigned MagBits   = svr_pkg::MAG_BITS;
  localparam int unsigned IdCmpBits = (VAR_ID_BITS > ExclBits) ? VAR_ID_BITS : ExclBits;

  localparam logic signed [63:0] ClampHi = (64'sd1 <<< MagBits) - 64'sd1;
  localparam logic signed [63:0] ClampLo = -ClampHi;
  localparam logic signed [SumBits-1:0] SumMax = {1'b0, {(SumBits-1){1'b1}}};
  localparam logic signed [SumBits-1:0] SumMin = {1'b1, {(SumBits-1){1'b0}}};
  localparam logic [MagBits-1:0] GcdOne = MagBits'(1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ALL      = 3'd1;
  localparam logic [2:0] S_ALL_WAIT = 3'd2;
  localparam logic [2:0] S_EXC      = 3'd3;
  localparam logic [2:0] S_EXC_WAIT = 3'd4;
  localparam logic [2:0] S_END      = 3'd5;

  logic [2:0]                state_q, state_d;
  logic [ExclBits-1:0]       excl_q;
  logic [DimBits-1:0]        dim_q, dim_d;
  logic signed [SumBits-1:0] sum_q, sum_d;
  logic signed [ValBits-1:0] max_q, max_d, min_q, min_d;
  logic [MagBits-1:0]        gcd_all_q, gcd_all_d, gcd_exc_q, gcd_exc_d;
  logic                      seen_any_q, seen_any_d, seen_other_q, seen_other_d;
  logic [MagBits-1:0]        mag_q, mag_d;
  logic                      last_q, last_d;
  logic                      need_all_q, need_all_d, need_exc_q, need_exc_d;
  logic                      out_valid_q, out_valid_d;
  logic                      load_out;

  logic signed [63:0]        coeff_ext;
  logic signed [ValBits-1:0] c_val;
  logic [MagBits-1:0]        mag;
  logic signed [SumBits:0]   sum_wide;
  logic signed [SumBits-1:0] sum_sat;
  logic                      id_hit;

  svr_pkg::gcd_req_t gcd_req;
  svr_pkg::gcd_rsp_t gcd_rsp;

  // clamp the most negative value so every magnitude fits
  assign coeff_ext = 64'(coeff_i);

  always_comb begin
    if (coeff_ext > ClampHi) begin
      c_val = ValBits'(ClampHi);
    end else if (coeff_ext < ClampLo) begin
      c_val = ValBits'(ClampLo);
    end else begin
      c_val = ValBits'(coeff_ext);
    end
  end

  assign mag = c_val[ValBits-1] ? MagBits'(-c_val) : MagBits'(c_val);

  assign sum_wide = (SumBits+1)'(sum_q) + (SumBits+1)'(c_val);

  always_comb begin
    if (sum_wide[SumBits] != sum_wide[SumBits-1]) begin
      sum_sat = sum_wide[SumBits] ? SumMin : SumMax;
    end else begin
      sum_sat = sum_wide[SumBits-1:0];
    end
  end

  assign id_hit = (IdCmpBits'(variable_id_i) == IdCmpBits'(excl_q));

  always_comb begin
    state_d      = state_q;
    dim_d        = dim_q;
    sum_d        = sum_q;
    max_d        = max_q;
    min_d        = min_q;
    gcd_all_d    = gcd_all_q;
    gcd_exc_d    = gcd_exc_q;
    seen_any_d   = seen_any_q;
    seen_other_d = seen_other_q;
    mag_d        = mag_q;
    last_d       = last_q;
    need_all_d   = need_all_q;
    need_exc_d   = need_exc_q;
    load_out     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d     = last_i;
          mag_d      = mag;
          need_all_d = !no_term_i && (mag != '0);
          need_exc_d = !no_term_i && (mag != '0) && !id_hit;
          if (!no_term_i) begin
            if ((variable_id_i != '0) && (dim_q != '1)) begin
              dim_d = dim_q + 1'b1;
            end
            sum_d = sum_sat;
            if (c_val > max_q) begin
              max_d = c_val;
            end
            if (c_val < min_q) begin
              min_d = c_val;
            end
          end
          state_d = S_ALL;
        end
      end
      S_ALL: begin
        if (need_all_q && seen_any_q) begin
          state_d = S_ALL_WAIT;
        end else begin
          if (need_all_q) begin
            gcd_all_d  = mag_q;
            seen_any_d = 1'b1;
          end
          state_d = S_EXC;
        end
      end
      S_ALL_WAIT: begin
        if (gcd_rsp.done) begin
          gcd_all_d = gcd_rsp.result;
          state_d   = S_EXC;
        end
      end
      S_EXC: begin
        if (need_exc_q && seen_other_q) begin
          state_d = S_EXC_WAIT;
        end else begin
          if (need_exc_q) begin
            gcd_exc_d    = mag_q;
            seen_other_d = 1'b1;
          end
          state_d = S_END;
        end
      end
      S_EXC_WAIT: begin
        if (gcd_rsp.done) begin
          gcd_exc_d = gcd_rsp.result;
          state_d   = S_END;
        end
      end
      S_END: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          load_out     = 1'b1;
          dim_d        = '0;
          sum_d        = '0;
          max_d        = '0;
          min_d        = '0;
          gcd_all_d    = GcdOne;
          gcd_exc_d    = GcdOne;
          seen_any_d   = 1'b0;
          seen_other_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign gcd_req.start = ((state_q == S_ALL) && need_all_q && seen_any_q) ||
                         ((state_q == S_EXC) && need_exc_q && seen_other_q);
  assign gcd_req.a     = (state_q == S_EXC) ? gcd_exc_q : gcd_all_q;
  assign gcd_req.b     = mag_q;

  svr_gcd u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (gcd_req),
    .rsp_o  (gcd_rsp)
  );

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      excl_q       <= '0;
      dim_q        <= '0;
      sum_q        <= '0;
      max_q        <= '0;
      min_q        <= '0;
      gcd_all_q    <= GcdOne;
      gcd_exc_q    <= GcdOne;
      seen_any_q   <= 1'b0;
      seen_other_q <= 1'b0;
      last_q       <= 1'b0;
      need_all_q   <= 1'b0;
      need_exc_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_valid_i) begin
        excl_q <= cfg_data_i;
      end
      dim_q        <= dim_d;
      sum_q        <= sum_d;
      max_q        <= max_d;
      min_q        <= min_d;
      gcd_all_q    <= gcd_all_d;
      gcd_exc_q    <= gcd_exc_d;
      seen_any_q   <= seen_any_d;
      seen_other_q <= seen_other_d;
      last_q       <= last_d;
      need_all_q   <= need_all_d;
      need_exc_q   <= need_exc_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    if (load_out) begin
      dimension_o   <= dim_q;
      coeff_sum_o   <= sum_q;
      max_or_zero_o <= max_q[MagBits-1:0];
      min_or_zero_o <= min_q;
      gcd_all_o     <= gcd_all_q;
      gcd_except_o  <= gcd_exc_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `SVR_ASSERT_NEXT(a_busy_after_beat, in_valid_i && !in_stall_o, in_stall_o)
  `SVR_ASSERT_NOW(a_gcd_nonzero, 1'b1, (gcd_all_q != '0) && (gcd_exc_q != '0))
  `SVR_ASSERT_NOW(a_seen_order, seen_other_q, seen_any_q)
  `SVR_ASSERT_NOW(a_gcd_done_waiting, gcd_rsp.done,
                  (state_q == S_ALL_WAIT) || (state_q == S_EXC_WAIT))

endmodule
